// ===== hw/rtl/tmf_pkg.sv =====
// Package for the tagged message FIFO: queue sizing, mode and status codes,
// and the packed types for transactions, stored entries and cell control.
// No dependencies; every other file imports it.
package tmf_pkg;

	// Queue sizing.
	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Operation codes carried in the mode field.
	localparam logic [2:0] MODE_PUT    = 3'd0;
	localparam logic [2:0] MODE_GET    = 3'd1;
	localparam logic [2:0] MODE_REMOVE = 3'd2;
	localparam logic [2:0] MODE_COUNT  = 3'd3;
	localparam logic [2:0] MODE_START  = 3'd4;
	localparam logic [2:0] MODE_ABORT  = 3'd5;
	localparam logic [2:0] MODE_FLUSH  = 3'd6;

	// Result status codes.
	localparam logic [2:0] ST_DELIVERED = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_ABORTED   = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_DONE      = 3'd4;
	localparam logic [2:0] ST_PENDING   = 3'd5;

	// Input transaction.
	typedef struct packed {
		logic [2:0]         mode;
		logic               blocking;
		logic [15:0]        msg_type;
		logic signed [31:0] first_arg;
		logic signed [31:0] second_arg;
	} msg_item_t;

	// Result transaction.
	typedef struct packed {
		logic [2:0]         status;
		logic [15:0]        out_type;
		logic signed [31:0] out_first;
		logic signed [31:0] out_second;
		logic [CNT_W-1:0]   match_count;
		logic               last;
	} msg_result_t;

	// One stored message.
	typedef struct packed {
		logic [15:0]        etype;
		logic signed [31:0] efirst;
		logic signed [31:0] esecond;
	} entry_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic             shift;
		logic             wr_en;
		logic [PTR_W-1:0] wr_ptr;
		entry_t           wr_entry;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/tmf_cell.sv =====
// One storage cell of the message chain: holds a single entry and either
// loads the broadcast write entry or takes its neighbor's entry.
// Depends on tmf_pkg.
module tmf_cell import tmf_pkg::*; (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [PTR_W-1:0] cell_idx,
	input  entry_t           next_entry,
	output entry_t           entry
);

	entry_t entry_q;

	// A write addressed to this cell wins over the shift toward the head.
	always_ff @(posedge clk) begin
		if (ctl.wr_en && (ctl.wr_ptr == cell_idx)) begin
			entry_q <= ctl.wr_entry;
		end else if (ctl.shift) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule

// ===== hw/rtl/tmf_chain.sv =====
// Row of message cells with the queue head in cell zero; each shift moves
// every entry one place toward the head. Depends on tmf_pkg and tmf_cell.
module tmf_chain import tmf_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	output entry_t    head
);

	entry_t cell_w [QUEUE_DEPTH];

	// Each cell takes the entry of the cell behind it; the last closes the ring.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		tmf_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.cell_idx   (PTR_W'(i)),
			.next_entry (cell_w[(i + 1) % QUEUE_DEPTH]),
			.entry      (cell_w[i])
		);
	end

	assign head = cell_w[0];

endmodule

// ===== hw/rtl/tagged_message_fifo.sv =====
// Top level of the tagged message FIFO: operation decode, occupancy and
// abort tracking, the remove/count walk and the two-entry result buffer.
// Depends on tmf_pkg and tmf_chain.
//
//  Channel   Direction  Handshake               Payload
//  in        input      in_valid / in_stall     in_data  (msg_item_t)
//  out       output     out_valid / out_stall   out_data (msg_result_t)
//  cfg       input      cfg_valid / cfg_ready   cfg_data (flush type code)
//
// Put, get, start, abort and flush write their result into the buffer when accepted,
// and it is presented from the next cycle. Remove and count shift the cell chain
// once per stored entry (up to QUEUE_DEPTH) before their result is written.
// A new transaction is taken only when the walk is over and all results of
// the previous one have left; out_stall simply holds the result buffer.
// Reset clears occupancy and the pending get and sets the abort flag; the
// cell contents are not reset. Configuration writes are always accepted.
module tagged_message_fifo import tmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  msg_item_t   in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output msg_result_t out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	state_t           state_q, state_n;
	logic [CNT_W-1:0] occ_q, occ_n;
	logic             abort_q, abort_n;
	logic             wait_q, wait_n;
	logic [15:0]      flush_code_q;
	logic [CNT_W-1:0] rem_q, rem_n;
	logic [CNT_W-1:0] kept_q, kept_n;
	logic [CNT_W-1:0] hit_q, hit_n;
	logic             remove_q, remove_n;
	logic [15:0]      match_q, match_n;
	logic [1:0]       res_cnt_q, res_cnt_n;
	msg_result_t      res_q [2];
	msg_result_t      res_n [2];

	cell_ctl_t        ctl;
	entry_t           head;
	entry_t           put_entry;
	logic             in_acc;
	logic             out_acc;
	logic             hit;
	logic             keep;
	logic [CNT_W-1:0] wp_sum;

	// Builds one result transaction; last is set by the caller.
	function automatic msg_result_t mk_result(
		input logic [2:0]       status,
		input entry_t           ent,
		input logic [CNT_W-1:0] cnt,
		input logic             fin
	);
		msg_result_t r;
		r.status      = status;
		r.out_type    = ent.etype;
		r.out_first   = ent.efirst;
		r.out_second  = ent.esecond;
		r.match_count = cnt;
		r.last        = fin;
		return r;
	endfunction

	tmf_chain u_chain (
		.clk  (clk),
		.ctl  (ctl),
		.head (head)
	);

	// Handshakes.
	assign in_stall  = (state_q != S_IDLE) || (res_cnt_q != 2'd0);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (res_cnt_q != 2'd0);
	assign out_acc   = out_valid && !out_stall;
	assign out_data  = res_q[0];
	assign cfg_ready = 1'b1;

	// Walk step: compare the head, decide whether it goes back into the chain.
	assign hit    = (head.etype == match_q);
	assign keep   = remove_q ? !hit : 1'b1;
	assign wp_sum = rem_q - CNT_W'(1) + kept_q;

	// Message appended by put or start.
	always_comb begin
		if (in_data.mode == MODE_START) begin
			put_entry = '{etype: flush_code_q, efirst: '0, esecond: '0};
		end else begin
			put_entry = '{etype: in_data.msg_type, efirst: in_data.first_arg,
				esecond: in_data.second_arg};
		end
	end

	// Operation decode and next-state logic.
	always_comb begin
		state_n   = state_q;
		occ_n     = occ_q;
		abort_n   = abort_q;
		wait_n    = wait_q;
		rem_n     = rem_q;
		kept_n    = kept_q;
		hit_n     = hit_q;
		remove_n  = remove_q;
		match_n   = match_q;
		ctl       = '0;
		res_cnt_n = res_cnt_q;
		res_n[0]  = res_q[0];
		res_n[1]  = res_q[1];

		// The downstream side takes the front result.
		if (out_acc) begin
			res_n[0]  = res_q[1];
			res_cnt_n = res_cnt_q - 2'd1;
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					unique case (in_data.mode)
						MODE_PUT, MODE_START: begin
							if (in_data.mode == MODE_START) begin
								abort_n = 1'b0;
							end
							if (abort_q && (in_data.mode == MODE_PUT)) begin
								res_n[0]  = mk_result(ST_ABORTED, '0, '0, 1'b1);
								res_cnt_n = 2'd1;
							end else if (occ_q == CNT_W'(QUEUE_DEPTH)) begin
								res_n[0]  = mk_result(ST_FULL, '0, '0, 1'b1);
								res_cnt_n = 2'd1;
							end else if (wait_q) begin
								// A pending get means the queue is empty, so the new
								// message goes straight out.
								wait_n    = 1'b0;
								res_n[0]  = mk_result(ST_DONE, '0, '0, 1'b0);
								res_n[1]  = mk_result(ST_DELIVERED, put_entry, '0, 1'b1);
								res_cnt_n = 2'd2;
							end else begin
								ctl.wr_en    = 1'b1;
								ctl.wr_ptr   = occ_q[PTR_W-1:0];
								ctl.wr_entry = put_entry;
								occ_n        = occ_q + CNT_W'(1);
								res_n[0]     = mk_result(ST_DONE, '0, '0, 1'b1);
								res_cnt_n    = 2'd1;
							end
						end
						MODE_GET: begin
							res_cnt_n = 2'd1;
							if (abort_q) begin
								res_n[0] = mk_result(ST_ABORTED, '0, '0, 1'b1);
							end else if (occ_q != '0) begin
								ctl.shift = 1'b1;
								occ_n     = occ_q - CNT_W'(1);
								res_n[0]  = mk_result(ST_DELIVERED, head, '0, 1'b1);
							end else if (!in_data.blocking) begin
								res_n[0] = mk_result(ST_EMPTY, '0, '0, 1'b1);
							end else begin
								wait_n   = 1'b1;
								res_n[0] = mk_result(ST_PENDING, '0, '0, 1'b1);
							end
						end
						MODE_REMOVE, MODE_COUNT: begin
							if (abort_q) begin
								res_n[0]  = mk_result(ST_ABORTED, '0, '0, 1'b1);
								res_cnt_n = 2'd1;
							end else if (occ_q == '0) begin
								res_n[0]  = mk_result(ST_DONE, '0, '0, 1'b1);
								res_cnt_n = 2'd1;
							end else begin
								state_n  = S_WALK;
								rem_n    = occ_q;
								kept_n   = '0;
								hit_n    = '0;
								remove_n = (in_data.mode == MODE_REMOVE);
								match_n  = in_data.msg_type;
							end
						end
						MODE_ABORT: begin
							abort_n = 1'b1;
							if (wait_q) begin
								wait_n    = 1'b0;
								res_n[0]  = mk_result(ST_DONE, '0, '0, 1'b0);
								res_n[1]  = mk_result(ST_ABORTED, '0, '0, 1'b1);
								res_cnt_n = 2'd2;
							end else begin
								res_n[0]  = mk_result(ST_DONE, '0, '0, 1'b1);
								res_cnt_n = 2'd1;
							end
						end
						MODE_FLUSH: begin
							occ_n     = '0;
							res_n[0]  = mk_result(ST_DONE, '0, '0, 1'b1);
							res_cnt_n = 2'd1;
						end
						default: begin
							// The unused code is dropped without a result.
						end
					endcase
				end
			end
			S_WALK: begin
				// The head leaves; kept entries are written back behind the
				// entries not yet examined.
				ctl.shift    = 1'b1;
				ctl.wr_en    = keep;
				ctl.wr_ptr   = wp_sum[PTR_W-1:0];
				ctl.wr_entry = head;
				rem_n        = rem_q - CNT_W'(1);
				kept_n       = kept_q + CNT_W'(keep);
				hit_n        = hit_q + CNT_W'(hit);
				if (rem_q == CNT_W'(1)) begin
					state_n   = S_IDLE;
					res_cnt_n = 2'd1;
					if (remove_q) begin
						occ_n    = kept_q + CNT_W'(keep);
						res_n[0] = mk_result(ST_DONE, '0, '0, 1'b1);
					end else begin
						res_n[0] = mk_result(ST_DONE, '0, hit_q + CNT_W'(hit), 1'b1);
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			occ_q        <= '0;
			abort_q      <= 1'b1;
			wait_q       <= 1'b0;
			res_cnt_q    <= 2'd0;
			flush_code_q <= '0;
		end else begin
			state_q   <= state_n;
			occ_q     <= occ_n;
			abort_q   <= abort_n;
			wait_q    <= wait_n;
			res_cnt_q <= res_cnt_n;
			if (cfg_valid && cfg_ready) begin
				flush_code_q <= cfg_data;
			end
		end
	end

	// Walk bookkeeping and result payloads.
	always_ff @(posedge clk) begin
		rem_q    <= rem_n;
		kept_q   <= kept_n;
		hit_q    <= hit_n;
		remove_q <= remove_n;
		match_q  <= match_n;
		res_q[0] <= res_n[0];
		res_q[1] <= res_n[1];
	end

	// A get can only be pending on an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) wait_q |-> (occ_q == '0))
		else $error("pending get with a non-empty queue");

	// Occupancy never exceeds the chain length.
	assert property (@(posedge clk) disable iff (!arst_n) occ_q <= CNT_W'(QUEUE_DEPTH))
		else $error("occupancy beyond queue depth");

	// During a walk no result is waiting and no transaction is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> ((res_cnt_q == 2'd0) && !in_acc))
		else $error("walk overlaps results or input");

	// The walk never runs with nothing left to examine.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (rem_q != '0) && (rem_q <= occ_q))
		else $error("walk counter out of range");

	// The result buffer holds at most two results.
	assert property (@(posedge clk) disable iff (!arst_n) res_cnt_q != 2'd3)
		else $error("result buffer overflow");

endmodule
